@@ rtl/core/lsab_pkg.sv @@
// shared types, codes and reset constants for the lidar angular binning block
package lsab_pkg;

  localparam int DEFAULT_MAX_BINS = 512;

  localparam int ANGLE_W     = 16;
  localparam int RANGE_W     = 16;
  localparam int INTENSITY_W = 8;
  localparam int INDEX_W     = 9;
  localparam int BIN_COUNT_W = 10;
  localparam int FUNC_W      = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 32;

  localparam logic [INTENSITY_W-1:0] RST_INTENSITY_FLOOR = 8'd10;
  localparam logic [RANGE_W-1:0]     RST_MIN_DISTANCE    = 16'd200;
  localparam logic [RANGE_W-1:0]     RST_MAX_DISTANCE    = 16'd6000;
  localparam logic [BIN_COUNT_W-1:0] RST_BIN_COUNT       = 10'd360;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILL   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INTENSITY_FLOOR = 4'd0,
    CFG_MIN_DISTANCE    = 4'd1,
    CFG_MAX_DISTANCE    = 4'd2,
    CFG_BIN_COUNT       = 4'd3
  } cfg_index_t;

  typedef struct packed {
    logic [INTENSITY_W-1:0] intensity_floor;
    logic [RANGE_W-1:0]     min_distance_mm;
    logic [RANGE_W-1:0]     max_distance_mm;
    logic [BIN_COUNT_W-1:0] bin_count;
  } cfg_t;

endpackage

@@ rtl/core/lsab_bin_map.sv @@
// maps a beam angle to its angular bin and applies the intensity and distance gate
module lsab_bin_map
  import lsab_pkg::*;
#(
  parameter int MAX_BINS = DEFAULT_MAX_BINS,
  parameter int AW       = $clog2(MAX_BINS)
) (
  input  cfg_t                   cfg,
  input  logic [ANGLE_W-1:0]     beam_angle,
  input  logic [RANGE_W-1:0]     range_mm,
  input  logic [INTENSITY_W-1:0] return_intensity,
  output logic [AW-1:0]          bin,
  output logic                   pass
);

  localparam int CW = (BIN_COUNT_W > $clog2(MAX_BINS + 1)) ? BIN_COUNT_W
                                                           : $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_BINS);

  logic [CW-1:0]         count_w;
  logic [CW-1:0]         n;
  logic [ANGLE_W-1:0]    biased;
  logic [ANGLE_W+CW-1:0] product;

  always_comb begin
    count_w = CW'(cfg.bin_count);
    if (count_w == '0) begin
      n = CW'(1);
    end else if (count_w > MAX_N) begin
      n = MAX_N;
    end else begin
      n = count_w;
    end
  end

  // flipping the sign bit adds a half turn
  assign biased  = {~beam_angle[ANGLE_W-1], beam_angle[ANGLE_W-2:0]};
  assign product = (ANGLE_W+CW)'(biased) * (ANGLE_W+CW)'(n);
  assign bin     = product[ANGLE_W+AW-1:ANGLE_W];

  assign pass = (return_intensity >= cfg.intensity_floor)
             && (range_mm > cfg.min_distance_mm)
             && (range_mm < cfg.max_distance_mm);

endmodule

@@ rtl/core/lidar_scan_angular_binning.sv @@
// top level of the lidar angular binning block: bin table, fill sweep and read path
//
// items arrive on the s_ stream: s_tuser carries the function (fill, sample,
// read) and s_tdata the angle, range, intensity and read index. a request is
// taken on s_tvalid && s_tready.
// sample and fill requests give no result; a read request gives one result
// on the m_ stream with the stored distance and the bin number.
// a read passes the input register, then the result register, to m_tvalid.
// throughput: one request per cycle while no sweep runs and no read stalls,
// set by the single write and read port of the bin table. a fill request starts
// a sweep that writes max_distance_mm into every one of the MAX_BINS entries,
// one per cycle, and s_tready stays low while it runs. after reset the same
// sweep clears the table to zero before the first request is taken; configuration
// writes are always taken. when the receiver stalls, the result holds in the
// output register, samples and fills still pass, and one more read is taken
// into the input register; then s_tready drops. the cfg_ channel writes register
// cfg_index with cfg_data on cfg_valid && cfg_ready; unknown indexes are ignored.
module lidar_scan_angular_binning
  import lsab_pkg::*;
#(
  parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // beam_angle[15:0], range_mm[31:16], return_intensity[39:32], read_index[48:40]
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // func[1:0]
  input  logic [FUNC_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // bin_distance_mm[15:0], bin_number[24:16]
  output logic [M_TDATA_W-1:0]   m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);
  localparam logic [IW-1:0] DEPTH_I   = IW'(MAX_BINS);

  cfg_t cfg;

  logic                   s1_valid;
  logic [FUNC_W-1:0]      s1_func;
  logic [ANGLE_W-1:0]     s1_angle;
  logic [RANGE_W-1:0]     s1_range;
  logic [INTENSITY_W-1:0] s1_intensity;
  logic [INDEX_W-1:0]     s1_index;

  logic                   sweeping;
  logic [AW-1:0]          sweep_addr;
  logic [RANGE_W-1:0]     fill_value;

  logic [RANGE_W-1:0]     mem [MAX_BINS];
  logic [RANGE_W-1:0]     rd_data;
  logic                   rd_oob;
  logic [INDEX_W-1:0]     out_number;

  logic [AW-1:0]          map_bin;
  logic                   map_pass;
  logic                   s1_adv;
  logic                   adv_read;
  logic                   adv_fill;
  logic                   samp_we;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [RANGE_W-1:0]     mem_wd;
  logic [IW-1:0]          index_w;
  logic [AW-1:0]          rd_addr;
  logic                   take;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intensity_floor <= RST_INTENSITY_FLOOR;
      cfg.min_distance_mm <= RST_MIN_DISTANCE;
      cfg.max_distance_mm <= RST_MAX_DISTANCE;
      cfg.bin_count       <= RST_BIN_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTENSITY_FLOOR: cfg.intensity_floor <= cfg_data[INTENSITY_W-1:0];
        CFG_MIN_DISTANCE:    cfg.min_distance_mm <= cfg_data[RANGE_W-1:0];
        CFG_MAX_DISTANCE:    cfg.max_distance_mm <= cfg_data[RANGE_W-1:0];
        CFG_BIN_COUNT:       cfg.bin_count       <= cfg_data[BIN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_comb begin
    adv_read = 1'b0;
    adv_fill = 1'b0;
    s1_adv   = 1'b0;
    if (s1_valid && !sweeping) begin
      case (s1_func)
        FUNC_READ: begin
          s1_adv   = !m_tvalid || m_tready;
          adv_read = s1_adv;
        end
        FUNC_FILL: begin
          s1_adv   = 1'b1;
          adv_fill = 1'b1;
        end
        default: s1_adv = 1'b1;
      endcase
    end
  end

  assign s_tready = !sweeping && (!s1_valid || s1_adv);
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_func      <= s_tuser;
      s1_angle     <= s_tdata[15:0];
      s1_range     <= s_tdata[31:16];
      s1_intensity <= s_tdata[39:32];
      s1_index     <= s_tdata[48:40];
    end
  end

  lsab_bin_map #(
    .MAX_BINS (MAX_BINS),
    .AW       (AW)
  ) u_bin_map (
    .cfg              (cfg),
    .beam_angle       (s1_angle),
    .range_mm         (s1_range),
    .return_intensity (s1_intensity),
    .bin              (map_bin),
    .pass             (map_pass)
  );

  // fill sweep, also run as the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      fill_value <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + AW'(1);
      if (sweep_addr == LAST_ADDR) begin
        sweeping <= 1'b0;
      end
    end else if (adv_fill) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      fill_value <= cfg.max_distance_mm;
    end
  end

  // bin table
  assign samp_we = s1_adv && (s1_func == FUNC_SAMPLE) && map_pass;
  assign mem_we  = sweeping || samp_we;
  assign mem_wa  = sweeping ? sweep_addr : map_bin;
  assign mem_wd  = sweeping ? fill_value : s1_range;

  assign index_w = IW'(s1_index);
  assign rd_addr = index_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (adv_read) begin
      rd_data    <= mem[rd_addr];
      rd_oob     <= index_w >= DEPTH_I;
      out_number <= s1_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, out_number, (rd_oob ? {RANGE_W{1'b0}} : rd_data)};

  a_reset_starts_clear: assert property (@(posedge clk)
    rst |=> sweeping && (sweep_addr == '0) && (fill_value == '0))
    else $error("reset did not start the clearing pass");

  a_no_request_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !s_tready && !s1_adv)
    else $error("request taken during table sweep");

  a_sweep_owns_write: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !samp_we)
    else $error("sample write collided with table sweep");

  a_read_needs_slot: assert property (@(posedge clk) disable iff (rst)
    adv_read |-> (!m_tvalid || m_tready))
    else $error("read overwrote a pending result");

  a_fill_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    adv_fill |=> sweeping && (sweep_addr == '0))
    else $error("fill request did not start a sweep");

endmodule

@@ verif/lidar_scan_angular_binning_test.sv @@
`timescale 1ns / 100ps
// testbench for lidar_scan_angular_binning: bin table predictor, stream driver and result checker
module lidar_scan_angular_binning_test;
  import lsab_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_MAX_BINS;
  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam int PHASE_ITEMS = 210;
  localparam int PHASE_COUNT = 9;
  localparam int SETTLE_CYCLES = DEFAULT_MAX_BINS + 64;
  // the slowest legal run stays well under this limit, which leaves a wide margin
  localparam int CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic signed [ANGLE_W-1:0] beam_angle;
    logic [RANGE_W-1:0]     range_mm;
    logic [INTENSITY_W-1:0] return_intensity;
    logic [INDEX_W-1:0]     read_index;
  } scan_req_t;

  typedef struct packed {
    logic [RANGE_W-1:0] bin_distance_mm;
    logic [INDEX_W-1:0] bin_number;
  } bin_result_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lidar_scan_angular_binning DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [RANGE_W-1:0] bin_table_model [TABLE_DEPTH];
  logic [INTENSITY_W-1:0] intensity_floor_cfg = RST_INTENSITY_FLOOR;
  logic [RANGE_W-1:0] min_range_cfg = RST_MIN_DISTANCE;
  logic [RANGE_W-1:0] max_range_cfg = RST_MAX_DISTANCE;
  logic [BIN_COUNT_W-1:0] bin_count_cfg = RST_BIN_COUNT;

  scan_req_t pending_requests[$];
  bin_result_t expected_reads[$];
  scan_req_t driven_req;
  bit req_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  rx_style_t rx_style = RX_OPEN;
  int rx_span = 0;
  int rx_tick = 0;

  int queued_items = 0;
  int requests_taken = 0;
  int fills_seen = 0;
  int samples_stored = 0;
  int samples_gated = 0;
  int ignored_seen = 0;
  int reads_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  initial begin
    foreach (bin_table_model[i]) bin_table_model[i] = '0;
  end

  function automatic int unsigned bins_in_use();
    int unsigned n;
    n = bin_count_cfg;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic int unsigned beam_to_bin(input logic [ANGLE_W-1:0] angle);
    int unsigned biased;
    int unsigned n;
    int unsigned b;
    // flipping the sign bit adds half a turn
    biased = {~angle[ANGLE_W-1], angle[ANGLE_W-2:0]};
    n = bins_in_use();
    b = (biased * n) >> 16;
    if (b >= n) b = n - 1;
    return b;
  endfunction

  task automatic apply_to_bin_table(input scan_req_t r);
    int unsigned b;
    bin_result_t res;
    case (r.func)
      FUNC_FILL: begin
        foreach (bin_table_model[i]) bin_table_model[i] = max_range_cfg;
        fills_seen++;
      end
      FUNC_SAMPLE: begin
        b = beam_to_bin(r.beam_angle);
        if (r.return_intensity >= intensity_floor_cfg && r.range_mm > min_range_cfg
            && r.range_mm < max_range_cfg && b < TABLE_DEPTH) begin
          bin_table_model[b] = r.range_mm;
          samples_stored++;
        end else begin
          samples_gated++;
        end
      end
      FUNC_READ: begin
        res.bin_distance_mm = (r.read_index < TABLE_DEPTH) ? bin_table_model[r.read_index] : '0;
        res.bin_number = r.read_index;
        expected_reads = {expected_reads, res};
      end
      default: ignored_seen++;
    endcase
  endtask

  function automatic scan_req_t make_req(input logic [FUNC_W-1:0] func, input int angle,
                                         input int rng, input int inten, input int idx);
    scan_req_t r;
    r.func = func;
    r.beam_angle = angle[15:0];
    r.range_mm = rng[15:0];
    r.return_intensity = inten[7:0];
    r.read_index = idx[8:0];
    return r;
  endfunction

  function automatic scan_req_t random_sample();
    scan_req_t r;
    int unsigned lo;
    int unsigned hi;
    r = make_req(FUNC_SAMPLE, $urandom(), $urandom(), $urandom(), $urandom());
    lo = min_range_cfg;
    hi = max_range_cfg;
    case ($urandom_range(0, 11))
      0: r.beam_angle = 16'h8000;
      1: r.beam_angle = 16'h7fff;
      2: r.beam_angle = 16'h0000;
      3: r.beam_angle = 16'hffff;
      default: ;
    endcase
    case ($urandom_range(0, 9)) inside
      [0:5]: if (hi > lo + 1) r.range_mm = 16'($urandom_range(lo + 1, hi - 1));
      6: r.range_mm = 16'(lo);
      7: r.range_mm = 16'(hi);
      8: r.range_mm = $urandom_range(0, 1) ? 16'(lo + 1) : 16'(hi - 1);
      default: ;
    endcase
    case ($urandom_range(0, 9)) inside
      [0:6]: r.return_intensity = 8'($urandom_range(intensity_floor_cfg, 255));
      7: r.return_intensity = intensity_floor_cfg - 8'd1;
      8: r.return_intensity = intensity_floor_cfg;
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(input scan_req_t r);
    pending_requests = {pending_requests, r};
    if (r.func != FUNC_IGNORED) queued_items++;
  endtask

  task automatic queue_read(input int idx);
    queue_req(make_req(FUNC_READ, $urandom(), $urandom(), $urandom(), idx));
  endtask

  // a scan: optional fill, samples with some reads right behind them, then reads; or a short run of random requests
  task automatic queue_scan_burst();
    scan_req_t r;
    int unsigned hits[$];
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 12))
        queue_req(make_req(FUNC_W'($urandom_range(1, 3)), $urandom(), $urandom(),
                           $urandom(), $urandom()));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_req(make_req(FUNC_FILL, $urandom(), $urandom(), $urandom(), $urandom()));
      if ($urandom_range(0, 1) == 0) queue_read($urandom_range(0, TABLE_DEPTH - 1));
    end
    repeat ($urandom_range(2, 24)) begin
      r = random_sample();
      hits = {hits, beam_to_bin(r.beam_angle)};
      queue_req(r);
      if ($urandom_range(0, 3) == 0) queue_read(hits[$]);
    end
    repeat ($urandom_range(2, 12)) begin
      case ($urandom_range(0, 3)) inside
        [0:1]: queue_read(hits[$urandom_range(0, hits.size() - 1)]);
        2: queue_read($urandom_range(0, bins_in_use() - 1));
        default: queue_read($urandom_range(0, TABLE_DEPTH - 1));
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INTENSITY_FLOOR: intensity_floor_cfg = value[INTENSITY_W-1:0];
      CFG_MIN_DISTANCE: min_range_cfg = value;
      CFG_MAX_DISTANCE: max_range_cfg = value;
      CFG_BIN_COUNT: bin_count_cfg = value[BIN_COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused high bits of the data word are filled with noise
  task automatic program_gate(input logic [7:0] mi, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [9:0] nb);
    write_reg(CFG_INDEX_W'($urandom_range(CFG_BIN_COUNT + 1, (1 << CFG_INDEX_W) - 1)), $urandom());
    write_reg(CFG_INTENSITY_FLOOR, {8'($urandom()), mi});
    write_reg(CFG_MIN_DISTANCE, lo);
    write_reg(CFG_MAX_DISTANCE, hi);
    write_reg(CFG_BIN_COUNT, {6'($urandom()), nb});
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || s_tvalid || expected_reads.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request side: acceptance and prediction
  always @(posedge clk) begin
    req_accepted = !rst && s_tvalid && s_tready;
    if (req_accepted) begin
      requests_taken++;
      apply_to_bin_table(driven_req);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        driven_req = pending_requests.pop_front();
        s_tuser <= driven_req.func;
        s_tdata <= S_TDATA_W'({driven_req.read_index, driven_req.return_intensity,
                               driven_req.range_mm, driven_req.beam_angle});
        s_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 100);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_span = $urandom_range(16, 160);
    end else begin
      rx_span--;
    end
    rx_tick++;
    case (rx_style)
      RX_OPEN: m_tready <= 1'b1;
      RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_tready <= ($urandom_range(0, 9) < 3);
      default: m_tready <= (rx_tick % 7) > 3;
    endcase
  end

  // result side
  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.bin_distance_mm = m_tdata[15:0];
      got.bin_number = m_tdata[24:16];
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d bin %0d", got.bin_distance_mm,
                   got.bin_number);
      end else begin
        want = expected_reads.pop_front();
        reads_checked++;
        if (got.bin_distance_mm !== want.bin_distance_mm
            || got.bin_number !== want.bin_number) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: expected distance %0d bin %0d, got distance %0d bin %0d",
                     want.bin_distance_mm, want.bin_number, got.bin_distance_mm,
                     got.bin_number);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lidar_scan_angular_binning regression: fail");
      $finish;
    end
  end

  initial begin
    int target;
    int unsigned lo_pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: 360 bins, gate 10 / 200 / 6000
    queue_read(0);
    queue_read(TABLE_DEPTH - 1);
    queue_req(make_req(FUNC_IGNORED, $urandom(), $urandom(), $urandom(), $urandom()));
    queue_req(make_req(FUNC_FILL, 0, 0, 0, 0));
    queue_read(TABLE_DEPTH - 1);
    queue_req(make_req(FUNC_SAMPLE, -32768, 1000, 10, 0));
    queue_read(0);
    queue_req(make_req(FUNC_SAMPLE, 32767, 5999, 255, 511));
    queue_req(make_req(FUNC_SAMPLE, 0, 201, 200, 0));
    queue_req(make_req(FUNC_SAMPLE, 0, 200, 200, 0));
    queue_req(make_req(FUNC_SAMPLE, 0, 6000, 200, 0));
    queue_req(make_req(FUNC_SAMPLE, 0, 65535, 200, 0));
    queue_req(make_req(FUNC_SAMPLE, -1, 3000, 9, 0));
    queue_req(make_req(FUNC_SAMPLE, -1, 0, 255, 0));
    queue_req(make_req(FUNC_SAMPLE, 100, 4321, 11, 0));
    queue_read(0);
    queue_read(359);
    queue_read(180);
    queue_read(179);
    queue_read(360);
    queue_req(make_req(FUNC_IGNORED, -1, 65535, 255, 511));
    queue_read(100);
    wait_until_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: ;
        1: program_gate(8'd0, 16'd0, 16'hffff, 10'd512);
        2: program_gate(8'd255, 16'd100, 16'd8000, 10'd1);
        3: program_gate(8'd20, 16'd300, 16'd4000, 10'd0);
        4: program_gate(8'd5, 16'd1000, 16'd900, 10'h3ff);
        5: program_gate(8'd1, 16'hffff, 16'd0, 10'd7);
        6: program_gate(RST_INTENSITY_FLOOR, RST_MIN_DISTANCE, RST_MAX_DISTANCE, 10'd513);
        default: begin
          lo_pick = $urandom_range(0, 4000);
          program_gate(8'($urandom()), 16'(lo_pick), 16'($urandom_range(lo_pick, 65535)),
                       10'($urandom_range(1, 1023)));
        end
      endcase
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) queue_scan_burst();
      wait_until_drained();
    end

    if (expected_reads.size() != 0) mismatches += expected_reads.size();
    $display("ran %0d gate settings: %0d requests taken, %0d fills,",
             PHASE_COUNT, requests_taken, fills_seen,
             " %0d samples stored, %0d gated, %0d ignored",
             samples_stored, samples_gated, ignored_seen);
    $display("%0d bin reads checked, %0d mismatches", reads_checked, mismatches);
    if (mismatches == 0)
      $display("lidar_scan_angular_binning regression: pass");
    else
      $display("lidar_scan_angular_binning regression: fail");
    $finish;
  end

endmodule
